[sv/rsu_pkg.sv]
// Shared types, constants and helpers for the run-length screen unpacker.
package rsu_pkg;

    localparam int SCREEN_BYTES = 32768;
    localparam int WA_W         = $clog2(SCREEN_BYTES + 1);
    localparam int OUT_ADDR_W   = 15;
    localparam int HDR_W        = 5;
    localparam int CNT_W        = 7;
    localparam int HDR_RESET    = 16;

    localparam logic [WA_W-1:0] SCREEN_END  = WA_W'(SCREEN_BYTES);
    localparam logic [WA_W-1:0] SCREEN_LAST = WA_W'(SCREEN_BYTES - 1);

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;
    localparam logic [1:0] ST_SHORT    = 2'd2;
    localparam logic [1:0] ST_UNUSED   = 2'd3;

    localparam logic [1:0] CNT_NONE = 2'd0;
    localparam logic [1:0] CNT_ONE  = 2'd1;
    localparam logic [1:0] CNT_TWO  = 2'd2;
    localparam logic [1:0] CNT_BAD  = 2'd3;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_COMMAND,
        PH_LITERAL,
        PH_REPEAT,
        PH_DONE
    } phase_t;

    typedef enum logic {
        SQ_IDLE,
        SQ_EXEC
    } seq_t;

    function automatic logic [OUT_ADDR_W-1:0] out_addr(input logic [WA_W-1:0] wa);
        logic [WA_W+OUT_ADDR_W-1:0] ext;
        ext = (WA_W + OUT_ADDR_W)'(wa);
        return ext[OUT_ADDR_W-1:0];
    endfunction

    function automatic logic [1:0] end_status(input logic [WA_W-1:0] wa);
        return (wa == SCREEN_END) ? ST_OK : ST_SHORT;
    endfunction

endpackage

[sv/rle_screen_unpacker_core.sv]
// Run-length screen unpacker: header skip, command decode, repeat sequencer.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-------------------------------------------
//  in       | in_valid / in_stall   | data_byte, end_of_file
//  out      | out_valid / out_stall | first_byte, second_byte, byte_count,
//           |                       | out_address, run_last, image_done, status
//  cfg      | cfg_wr_en             | cfg_wr_data (header_length)
//
// A transaction is taken in idle, then worked in the exec state: header, command and
// literal bytes leave exec after their decode step; a repeat of N goes in pairs,
// one pair per cycle while the output is not stalled, through the address adder
// and screen compare. A new byte is taken only once the sequencer is back in idle.
// The one-entry output register lets a new transaction in while a result waits;
// exec stalls only while that register is full and stalled.
// Reset clears all control state; header_length returns to 16.
module rle_screen_unpacker_core
    import rsu_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [7:0]            data_byte,
    input  logic                  end_of_file,
    input  logic                  cfg_wr_en,
    input  logic [HDR_W-1:0]      cfg_wr_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [7:0]            first_byte,
    output logic [7:0]            second_byte,
    output logic [1:0]            byte_count,
    output logic [OUT_ADDR_W-1:0] out_address,
    output logic                  run_last,
    output logic                  image_done,
    output logic [1:0]            status
);

    seq_t                  seq_reg, seq_next;
    phase_t                phase_reg, phase_next, eff_phase;
    logic [HDR_W-1:0]      hlen_reg, hlen_next;
    logic [HDR_W-1:0]      hcount_reg, hcount_next;
    logic [CNT_W-1:0]      pending_reg, pending_next;
    logic [WA_W-1:0]       wa_reg, wa_next;
    logic [7:0]            byte_reg;
    logic                  eof_reg;

    logic                  out_valid_reg, out_valid_next;
    logic [7:0]            b0_reg, b1_reg;
    logic [1:0]            cnt_reg;
    logic [OUT_ADDR_W-1:0] addr_reg;
    logic                  last_reg, done_reg;
    logic [1:0]            status_reg;

    logic                  out_free, step_go, step_end, emit;
    logic [7:0]            e_b0, e_b1;
    logic [1:0]            e_cnt, e_status;
    logic                  e_last, e_done;
    logic                  pair;
    logic [WA_W-1:0]       wa_step;
    logic [CNT_W-1:0]      pend_step;

    assign out_free = !out_valid_reg || !out_stall;
    assign step_go  = (seq_reg == SQ_EXEC) && out_free;
    assign in_stall = (seq_reg != SQ_IDLE);

    // sequencer next state
    always_comb
    begin
        seq_next = seq_reg;
        case (seq_reg)
            SQ_IDLE:
            begin
                if (in_valid)
                    seq_next = SQ_EXEC;
            end
            SQ_EXEC:
            begin
                if (step_go && step_end)
                    seq_next = SQ_IDLE;
            end
            default: seq_next = SQ_IDLE;
        endcase
    end

    // one decode step
    always_comb
    begin
        eff_phase = phase_reg;
        if (phase_reg == PH_HEADER && hcount_reg >= hlen_reg)
            eff_phase = PH_COMMAND;

        phase_next   = eff_phase;
        hcount_next  = hcount_reg;
        pending_next = pending_reg;
        wa_next      = wa_reg;
        step_end     = 1'b1;
        emit         = 1'b0;
        e_b0         = 8'd0;
        e_b1         = 8'd0;
        e_cnt        = CNT_NONE;
        e_last       = 1'b1;
        e_done       = 1'b0;
        e_status     = ST_OK;

        pair      = (pending_reg >= CNT_W'(2)) && (wa_reg < SCREEN_LAST);
        wa_step   = wa_reg + (pair ? WA_W'(2) : WA_W'(1));
        pend_step = pending_reg - (pair ? CNT_W'(2) : CNT_W'(1));

        case (eff_phase)
            PH_HEADER:
            begin
                hcount_next = hcount_reg + HDR_W'(1);
                if (eof_reg)
                begin
                    emit       = 1'b1;
                    e_done     = 1'b1;
                    e_status   = end_status(wa_reg);
                    phase_next = PH_DONE;
                end
            end
            PH_COMMAND:
            begin
                if (byte_reg[7])
                begin
                    pending_next = byte_reg[6:0];
                    phase_next   = (byte_reg[6:0] != '0) ? PH_LITERAL : PH_COMMAND;
                end
                else
                begin
                    pending_next = byte_reg[6:0];
                    phase_next   = PH_REPEAT;
                end
                if (byte_reg == 8'd0 || eof_reg)
                begin
                    emit       = 1'b1;
                    e_done     = 1'b1;
                    e_status   = end_status(wa_reg);
                    phase_next = PH_DONE;
                end
            end
            PH_LITERAL:
            begin
                emit = 1'b1;
                if (wa_reg >= SCREEN_END)
                begin
                    e_done     = 1'b1;
                    e_status   = ST_OVERFLOW;
                    phase_next = PH_DONE;
                end
                else
                begin
                    e_b0         = byte_reg;
                    e_cnt        = CNT_ONE;
                    wa_next      = wa_reg + WA_W'(1);
                    pending_next = pending_reg - CNT_W'(1);
                    if (pending_reg == CNT_W'(1))
                        phase_next = PH_COMMAND;
                    if (eof_reg)
                    begin
                        e_done     = 1'b1;
                        e_status   = end_status(wa_reg + WA_W'(1));
                        phase_next = PH_DONE;
                    end
                end
            end
            PH_REPEAT:
            begin
                emit = 1'b1;
                if (wa_reg >= SCREEN_END)
                begin
                    e_done       = 1'b1;
                    e_status     = ST_OVERFLOW;
                    pending_next = '0;
                    phase_next   = PH_DONE;
                end
                else
                begin
                    e_b0         = byte_reg;
                    e_b1         = pair ? byte_reg : 8'd0;
                    e_cnt        = pair ? CNT_TWO : CNT_ONE;
                    wa_next      = wa_step;
                    pending_next = pend_step;
                    if (pend_step == '0)
                    begin
                        phase_next = PH_COMMAND;
                        if (eof_reg)
                        begin
                            e_done     = 1'b1;
                            e_status   = end_status(wa_step);
                            phase_next = PH_DONE;
                        end
                    end
                    else if (wa_step >= SCREEN_END)
                    begin
                        e_done       = 1'b1;
                        e_status     = ST_OVERFLOW;
                        pending_next = '0;
                        phase_next   = PH_DONE;
                    end
                    else
                    begin
                        e_last   = 1'b0;
                        step_end = 1'b0;
                    end
                end
            end
            PH_DONE:
            begin
                phase_next = PH_DONE;
            end
            default:
            begin
                phase_next = PH_DONE;
            end
        endcase
    end

    always_comb
    begin
        hlen_next = cfg_wr_en ? cfg_wr_data : hlen_reg;
        if (step_go && emit)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg       <= SQ_IDLE;
            phase_reg     <= PH_HEADER;
            hlen_reg      <= HDR_W'(HDR_RESET);
            hcount_reg    <= '0;
            pending_reg   <= '0;
            wa_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            seq_reg       <= seq_next;
            hlen_reg      <= hlen_next;
            out_valid_reg <= out_valid_next;
            if (step_go)
            begin
                phase_reg   <= phase_next;
                hcount_reg  <= hcount_next;
                pending_reg <= pending_next;
                wa_reg      <= wa_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (seq_reg == SQ_IDLE && in_valid)
        begin
            byte_reg <= data_byte;
            eof_reg  <= end_of_file;
        end
        if (step_go && emit)
        begin
            b0_reg     <= e_b0;
            b1_reg     <= e_b1;
            cnt_reg    <= e_cnt;
            addr_reg   <= out_addr(wa_reg);
            last_reg   <= e_last;
            done_reg   <= e_done;
            status_reg <= e_status;
        end
    end

    assign out_valid   = out_valid_reg;
    assign first_byte  = b0_reg;
    assign second_byte = b1_reg;
    assign byte_count  = cnt_reg;
    assign out_address = addr_reg;
    assign run_last    = last_reg;
    assign image_done  = done_reg;
    assign status      = status_reg;

endmodule

[sv/rsu_checker.sv]
// Port-level checks for the run-length screen unpacker, bound to the top level.
module rsu_checker
    import rsu_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  out_valid,
    input logic                  out_stall,
    input logic [7:0]            first_byte,
    input logic [7:0]            second_byte,
    input logic [1:0]            byte_count,
    input logic [OUT_ADDR_W-1:0] out_address,
    input logic                  run_last,
    input logic                  image_done,
    input logic [1:0]            status
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(first_byte)
            && $stable(byte_count) && $stable(out_address) && $stable(image_done))
        else $error("stalled result changed");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> byte_count != CNT_BAD && status != ST_UNUSED)
        else $error("byte count or status out of range");

    a_status_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !image_done |-> status == ST_OK)
        else $error("status set before image end");

    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && image_done |-> run_last)
        else $error("done result not last of its transaction");

    a_second_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && byte_count != CNT_TWO |-> second_byte == 8'd0)
        else $error("second byte set on short result");

endmodule

bind rle_screen_unpacker_core rsu_checker u_rsu_checker (.*);
